[rtl/bblci_pkg.sv]
// Shared types and constants for the byte-budget LRU cache index.
`timescale 1ns / 1ps
`default_nettype none
package bblci_pkg;

   // Operation codes carried in the request item.
   localparam logic [2:0] OP_STORE = 3'd0;
   localparam logic [2:0] OP_LOAD  = 3'd1;
   localparam logic [2:0] OP_PROBE = 3'd2;
   localparam logic [2:0] OP_INVAL = 3'd3;
   localparam logic [2:0] OP_RANGE = 3'd4;
   localparam logic [2:0] OP_CLEAR = 3'd5;
   localparam logic [2:0] OP_EVICT = 3'd6;
   localparam logic [2:0] OP_STATS = 3'd7;

   // Register indexes of the configuration port.
   localparam int          CSR_INDEX_W = 2;
   localparam int          CSR_DATA_W  = 12;
   localparam logic [1:0]  CSR_BUDGET  = 2'd0;
   localparam logic [1:0]  CSR_ENABLE  = 2'd1;
   localparam logic [11:0] BUDGET_RESET = 12'd1024;

   // Scan modes of the slot sweep.
   localparam logic [1:0] SCAN_FIND   = 2'd0;
   localparam logic [1:0] SCAN_OLDEST = 2'd1;
   localparam logic [1:0] SCAN_SWEEP  = 2'd2;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] frame_time;
      logic [31:0] range_end_time;
      logic [15:0] component_id;
      logic [13:0] frame_width;
      logic [13:0] frame_height;
      logic [31:0] byte_size;
   } req_type;

   typedef struct packed {
      logic        success;
      logic [13:0] hit_width;
      logic [13:0] hit_height;
      logic [5:0]  evicted_count;
      logic [5:0]  entry_count;
      logic [39:0] total_bytes;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
   } rsp_type;

   // One slot of the index as held in the slot memory.
   typedef struct packed {
      logic [31:0] frame_time;
      logic [15:0] component_id;
      logic [13:0] frame_width;
      logic [13:0] frame_height;
      logic [31:0] byte_size;
      logic [31:0] stamp;
   } slot_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       begin_item;
      logic       scan_go;
      logic [1:0] scan_mode;
      logic       remove_best;
      logic       write_store;
      logic       write_touch;
      logic       count_miss;
      logic       clear_stats;
      logic       load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic found;
      logic over_budget;
      logic table_full;
      logic enabled;
      logic rsp_free;
   } status_type;

endpackage
`default_nettype wire

[rtl/byte_budget_lru_cache_index.sv]
// Top level of the byte-budget LRU cache index.
`timescale 1ns / 1ps
`default_nettype none
// Index of up to ENTRIES cached frames keyed by time and component, with LRU
// eviction against a byte budget. One item is processed at a time. Every slot
// scan reads the slot memory one entry per cycle. Probe, load, invalidate,
// range invalidate and clear take one scan; reset stats takes none. Evict and
// a store of a new key add one scan per removed entry, the oldest entry of a
// full table included. A write of the budget register runs the same eviction
// loop without a result; the port stays busy until it ends. No memory clearing
// pass is needed after reset.
module byte_budget_lru_cache_index
   import bblci_pkg::*;
#(
   parameter int ENTRIES = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire req_type                req_item,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      rsp_type                rsp_item,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cmd_type    cmd;
   status_type status;

   bblci_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_item.operation),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .status        (status),
      .req_stall     (req_stall),
      .csr_ready     (csr_ready),
      .cmd           (cmd)
   );

   bblci_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire

[rtl/bblci_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bblci_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
   output      logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

[rtl/bblci_ctrl.sv]
// Controller state machine that sequences each operation over the slot scans.
`timescale 1ns / 1ps
`default_nettype none
module bblci_ctrl
   import bblci_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic [2:0]             req_operation,
   input  wire logic                   csr_valid,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire status_type             status,
   output      logic                   req_stall,
   output      logic                   csr_ready,
   output      cmd_type                cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DISP   = 4'd1;
   localparam logic [3:0] S_FIND   = 4'd2;
   localparam logic [3:0] S_EVAL   = 4'd3;
   localparam logic [3:0] S_EVCHK  = 4'd4;
   localparam logic [3:0] S_EVSCAN = 4'd5;
   localparam logic [3:0] S_EVRM   = 4'd6;
   localparam logic [3:0] S_FLCHK  = 4'd7;
   localparam logic [3:0] S_FLSCAN = 4'd8;
   localparam logic [3:0] S_FLRM   = 4'd9;
   localparam logic [3:0] S_WRITE  = 4'd10;
   localparam logic [3:0] S_SWEEP  = 4'd11;
   localparam logic [3:0] S_FINISH = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic       cfg_ff, cfg_in;
   logic       idle;
   logic       req_take;

   assign idle      = (state_ff == S_IDLE);
   assign csr_ready = idle;
   assign req_stall = !idle || csr_valid;
   assign req_take  = idle && req_valid && !csr_valid;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cfg_in   = cfg_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               if (csr_index == CSR_BUDGET) begin
                  cfg_in   = 1'b1;
                  state_in = S_EVCHK;
               end
            end else if (req_valid) begin
               cmd.begin_item = 1'b1;
               op_in          = req_operation;
               cfg_in         = 1'b0;
               state_in       = S_DISP;
            end
         end
         S_DISP: begin
            unique case (op_ff)
               OP_STORE: begin
                  if (status.enabled) begin
                     cmd.scan_go   = 1'b1;
                     cmd.scan_mode = SCAN_FIND;
                     state_in      = S_FIND;
                  end else begin
                     state_in = S_FINISH;
                  end
               end
               OP_LOAD, OP_PROBE: begin
                  cmd.scan_go   = 1'b1;
                  cmd.scan_mode = SCAN_FIND;
                  state_in      = S_FIND;
               end
               OP_INVAL, OP_RANGE, OP_CLEAR: begin
                  cmd.scan_go   = 1'b1;
                  cmd.scan_mode = SCAN_SWEEP;
                  state_in      = S_SWEEP;
               end
               OP_EVICT: state_in = S_EVCHK;
               default: begin
                  cmd.clear_stats = 1'b1;
                  state_in        = S_FINISH;
               end
            endcase
         end
         S_FIND: begin
            if (status.scan_done) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            priority if (op_ff == OP_STORE) begin
               state_in = status.found ? S_WRITE : S_EVCHK;
            end else if (op_ff == OP_LOAD) begin
               cmd.write_touch = status.found;
               cmd.count_miss  = !status.found;
               state_in        = S_FINISH;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_EVCHK: begin
            if (status.over_budget) begin
               cmd.scan_go   = 1'b1;
               cmd.scan_mode = SCAN_OLDEST;
               state_in      = S_EVSCAN;
            end else if (cfg_ff) begin
               state_in = S_IDLE;
            end else if (op_ff == OP_STORE) begin
               state_in = S_FLCHK;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_EVSCAN: begin
            if (status.scan_done) begin
               state_in = S_EVRM;
            end
         end
         S_EVRM: begin
            cmd.remove_best = 1'b1;
            state_in        = S_EVCHK;
         end
         S_FLCHK: begin
            if (status.table_full) begin
               cmd.scan_go   = 1'b1;
               cmd.scan_mode = SCAN_OLDEST;
               state_in      = S_FLSCAN;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_FLSCAN: begin
            if (status.scan_done) begin
               state_in = S_FLRM;
            end
         end
         S_FLRM: begin
            cmd.remove_best = 1'b1;
            state_in        = S_WRITE;
         end
         S_WRITE: begin
            cmd.write_store = 1'b1;
            state_in        = S_FINISH;
         end
         S_SWEEP: begin
            if (status.scan_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cfg_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cfg_ff   <= cfg_in;
      end
      op_ff <= op_in;
   end

   // An item is only taken from the idle state.
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_DISP))
      else $error("accepted item did not start dispatch");

   // Removal of an oldest entry always follows a completed oldest scan.
   assert property (@(posedge clock) disable iff (reset)
      cmd.remove_best |-> ($past(state_ff) == S_EVSCAN || $past(state_ff) == S_FLSCAN))
      else $error("removal without a preceding oldest scan");

   // A result is produced only for a request item, never for a budget write.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !cfg_ff)
      else $error("result produced during configuration eviction");

endmodule
`default_nettype wire

[rtl/bblci_dpath.sv]
// Datapath: slot memory, valid bits, scan pipeline, totals and counters.
`timescale 1ns / 1ps
`default_nettype none
module bblci_dpath
   import bblci_pkg::*;
#(
   parameter int ENTRIES = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire req_type                req_item,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   input  wire logic                   rsp_stall,
   input  wire cmd_type                cmd,
   output      status_type             status,
   output      logic                   rsp_valid,
   output      rsp_type                rsp_item
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int SLOT_W = $bits(slot_type);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   req_type               req_ff, req_in;
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [39:0]           total_ff, total_in;
   logic [31:0]           use_ff, use_in;
   logic [31:0]           hits_ff, hits_in;
   logic [31:0]           miss_ff, miss_in;
   logic [11:0]           budget_ff, budget_in;
   logic                  enable_ff, enable_in;
   logic                  scan_on_ff, scan_on_in;
   logic [IDX_W-1:0]      scan_addr_ff, scan_addr_in;
   logic                  proc_on_ff;
   logic [IDX_W-1:0]      proc_idx_ff;
   logic [1:0]            mode_ff, mode_in;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      hit_idx_ff, hit_idx_in;
   slot_type              hit_data_ff, hit_data_in;
   logic                  free_found_ff, free_found_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic                  best_found_ff, best_found_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [31:0]           best_age_ff, best_age_in;
   logic [31:0]           best_bytes_ff, best_bytes_in;
   logic [CNT_W-1:0]      evict_ff, evict_in;
   logic                  wrote_ff, wrote_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   slot_type              wr_slot;
   logic [SLOT_W-1:0]     rd_data;
   slot_type              rd_slot;
   logic                  proc_valid;
   logic                  key_match;
   logic                  sweep_match;
   logic [31:0]           age;
   logic [IDX_W-1:0]      store_idx;

   bblci_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (ENTRIES)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_slot),
      .rd_addr (scan_addr_ff),
      .rd_data (rd_data)
   );

   assign rd_slot    = slot_type'(rd_data);
   assign proc_valid = valid_ff[proc_idx_ff];
   assign key_match  = proc_valid && (rd_slot.frame_time == req_ff.frame_time)
                       && (rd_slot.component_id == req_ff.component_id);
   assign age        = use_ff - rd_slot.stamp;
   assign store_idx  = found_ff ? hit_idx_ff : free_idx_ff;

   // Match rule of the invalidate, range invalidate and clear sweeps.
   always_comb begin
      unique case (req_ff.operation)
         OP_INVAL: sweep_match = (rd_slot.component_id == req_ff.component_id)
                                 && (rd_slot.frame_time == req_ff.frame_time);
         OP_RANGE: sweep_match = (rd_slot.component_id == req_ff.component_id)
                                 && (rd_slot.frame_time >= req_ff.frame_time)
                                 && (rd_slot.frame_time <= req_ff.range_end_time);
         default:  sweep_match = 1'b1;
      endcase
   end

   // Status toward the controller.
   always_comb begin
      status.scan_done   = proc_on_ff && (proc_idx_ff == LAST_IDX);
      status.found       = found_ff;
      status.over_budget = (total_ff > {8'd0, budget_ff, 20'd0}) && (cnt_ff != '0);
      status.table_full  = (cnt_ff == CNT_W'(ENTRIES));
      status.enabled     = enable_ff;
      status.rsp_free    = !rsp_valid_ff || !rsp_stall;
   end

   // Datapath next-state logic.
   always_comb begin
      req_in        = req_ff;
      valid_in      = valid_ff;
      cnt_in        = cnt_ff;
      total_in      = total_ff;
      use_in        = use_ff;
      hits_in       = hits_ff;
      miss_in       = miss_ff;
      budget_in     = budget_ff;
      enable_in     = enable_ff;
      scan_on_in    = scan_on_ff;
      scan_addr_in  = scan_addr_ff;
      mode_in       = mode_ff;
      found_in      = found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_data_in   = hit_data_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_age_in   = best_age_ff;
      best_bytes_in = best_bytes_ff;
      evict_in      = evict_ff;
      wrote_in      = wrote_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = store_idx;
      wr_slot       = hit_data_ff;

      // Configuration writes.
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_BUDGET) begin
            budget_in = csr_data;
         end else if (csr_index == CSR_ENABLE) begin
            enable_in = csr_data[0];
         end
      end

      // Start of an item: take the request and clear per-item tracking.
      if (cmd.begin_item) begin
         req_in        = req_item;
         found_in      = 1'b0;
         free_found_in = 1'b0;
         evict_in      = '0;
         wrote_in      = 1'b0;
      end

      // Scan address sequencing.
      if (cmd.scan_go) begin
         scan_on_in    = 1'b1;
         scan_addr_in  = '0;
         mode_in       = cmd.scan_mode;
         best_found_in = 1'b0;
      end else if (scan_on_ff) begin
         scan_addr_in = scan_addr_ff + 1'b1;
         if (scan_addr_ff == LAST_IDX) begin
            scan_on_in = 1'b0;
         end
      end

      // Per-slot processing of the scan data.
      if (proc_on_ff) begin
         unique case (mode_ff)
            SCAN_FIND: begin
               if (key_match && !found_ff) begin
                  found_in    = 1'b1;
                  hit_idx_in  = proc_idx_ff;
                  hit_data_in = rd_slot;
               end
               if (!proc_valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = proc_idx_ff;
               end
            end
            SCAN_OLDEST: begin
               if (proc_valid && (!best_found_ff || age > best_age_ff)) begin
                  best_found_in = 1'b1;
                  best_idx_in   = proc_idx_ff;
                  best_age_in   = age;
                  best_bytes_in = rd_slot.byte_size;
               end
            end
            default: begin
               if (proc_valid && sweep_match) begin
                  valid_in[proc_idx_ff] = 1'b0;
                  total_in = total_ff - 40'(rd_slot.byte_size);
                  cnt_in   = cnt_ff - 1'b1;
                  evict_in = evict_ff + 1'b1;
               end
            end
         endcase
      end

      // Removal of the oldest entry; its slot becomes a free candidate.
      if (cmd.remove_best) begin
         valid_in[best_idx_ff] = 1'b0;
         total_in = total_ff - 40'(best_bytes_ff);
         cnt_in   = cnt_ff - 1'b1;
         evict_in = evict_ff + 1'b1;
         if (!free_found_ff || best_idx_ff < free_idx_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = best_idx_ff;
         end
      end

      // Store: overwrite an existing key or fill the lowest free slot.
      if (cmd.write_store) begin
         wr_en                = 1'b1;
         wr_addr              = store_idx;
         wr_slot.frame_time   = req_ff.frame_time;
         wr_slot.component_id = req_ff.component_id;
         wr_slot.frame_width  = req_ff.frame_width;
         wr_slot.frame_height = req_ff.frame_height;
         wr_slot.byte_size    = req_ff.byte_size;
         wr_slot.stamp        = use_ff;
         use_in               = use_ff + 1'b1;
         wrote_in             = 1'b1;
         valid_in[store_idx]  = 1'b1;
         if (found_ff) begin
            total_in = total_ff - 40'(hit_data_ff.byte_size) + 40'(req_ff.byte_size);
         end else begin
            total_in = total_ff + 40'(req_ff.byte_size);
            cnt_in   = cnt_ff + 1'b1;
         end
      end

      // Load hit: refresh the stamp and count the hit.
      if (cmd.write_touch) begin
         wr_en         = 1'b1;
         wr_addr       = hit_idx_ff;
         wr_slot.stamp = use_ff;
         use_in        = use_ff + 1'b1;
         if (hits_ff != '1) begin
            hits_in = hits_ff + 1'b1;
         end
      end

      if (cmd.count_miss && miss_ff != '1) begin
         miss_in = miss_ff + 1'b1;
      end

      if (cmd.clear_stats) begin
         hits_in = '0;
         miss_in = '0;
      end

      // Output register.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         unique case (req_ff.operation)
            OP_STORE:          rsp_in.success = wrote_ff;
            OP_LOAD, OP_PROBE: rsp_in.success = found_ff;
            OP_STATS:          rsp_in.success = 1'b0;
            default:           rsp_in.success = (evict_ff != '0);
         endcase
         if (req_ff.operation == OP_LOAD && found_ff) begin
            rsp_in.hit_width  = hit_data_ff.frame_width;
            rsp_in.hit_height = hit_data_ff.frame_height;
         end else begin
            rsp_in.hit_width  = '0;
            rsp_in.hit_height = '0;
         end
         rsp_in.evicted_count = 6'(evict_ff);
         rsp_in.entry_count   = 6'(cnt_ff);
         rsp_in.total_bytes   = total_ff;
         rsp_in.hit_total     = hits_ff;
         rsp_in.miss_total    = miss_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         cnt_ff       <= '0;
         total_ff     <= '0;
         use_ff       <= '0;
         hits_ff      <= '0;
         miss_ff      <= '0;
         budget_ff    <= BUDGET_RESET;
         enable_ff    <= 1'b0;
         scan_on_ff   <= 1'b0;
         proc_on_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         cnt_ff       <= cnt_in;
         total_ff     <= total_in;
         use_ff       <= use_in;
         hits_ff      <= hits_in;
         miss_ff      <= miss_in;
         budget_ff    <= budget_in;
         enable_ff    <= enable_in;
         scan_on_ff   <= scan_on_in;
         proc_on_ff   <= scan_on_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      scan_addr_ff  <= scan_addr_in;
      proc_idx_ff   <= scan_addr_ff;
      mode_ff       <= mode_in;
      found_ff      <= found_in;
      hit_idx_ff    <= hit_idx_in;
      hit_data_ff   <= hit_data_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      best_age_ff   <= best_age_in;
      best_bytes_ff <= best_bytes_in;
      evict_ff      <= evict_in;
      wrote_ff      <= wrote_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // The entry count tracks the valid bits.
   assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) == $countones(valid_ff))
      else $error("entry count differs from valid bits");

   // An oldest-entry removal always hits a valid slot.
   assert property (@(posedge clock) disable iff (reset)
      cmd.remove_best |-> (best_found_ff && valid_ff[best_idx_ff]))
      else $error("oldest removal of an empty slot");

   // A new store always lands in a free slot.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.write_store && !found_ff) |-> (free_found_ff && !valid_ff[free_idx_ff]))
      else $error("store without a free slot");

endmodule
`default_nettype wire

[tb/byte_budget_lru_cache_index_tb.sv]
// Self-checking testbench for the byte-budget LRU cache index.
`timescale 1ns / 1ps
module byte_budget_lru_cache_index_tb;
   import bblci_pkg::*;

   localparam int SLOTS      = 32;
   localparam int QUIET_WAIT = 100;
   localparam int WATCHDOG   = 40000;
   localparam int RAND_ITEMS = 1100;

   typedef enum int {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type               kind;
      req_type                    item;
      bit                         typed;
      rsp_type                    want;
      logic [CSR_INDEX_W-1:0]     csr_idx;
      logic [CSR_DATA_W-1:0]      csr_val;
   } row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_item;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_item;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   byte_budget_lru_cache_index #(.ENTRIES(SLOTS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Shadow copy of the cache index.
   bit          m_valid [SLOTS];
   logic [31:0] m_time  [SLOTS];
   logic [15:0] m_comp  [SLOTS];
   logic [13:0] m_width [SLOTS];
   logic [13:0] m_height[SLOTS];
   logic [31:0] m_bytes [SLOTS];
   logic [31:0] m_stamp [SLOTS];
   logic [31:0] use_ctr;
   logic [39:0] byte_sum;
   logic [31:0] hit_ctr;
   logic [31:0] miss_ctr;
   logic [11:0] budget_mb;
   bit          cache_on;

   rsp_type     expected_rsp_q[$];
   int          mismatch_count;
   int          idle_cycles;
   int          send_idle_pct;
   int          recv_idle_pct;
   row_type     directed[$];

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int count_slots();
      int n = 0;
      for (int i = 0; i < SLOTS; i++) if (m_valid[i]) n++;
      return n;
   endfunction

   function automatic int find_slot(logic [31:0] t, logic [15:0] c);
      for (int i = 0; i < SLOTS; i++)
         if (m_valid[i] && m_time[i] == t && m_comp[i] == c) return i;
      return -1;
   endfunction

   // The oldest entry has the largest wrapped age; ties go to the lowest slot.
   function automatic int oldest_slot();
      int          best = -1;
      logic [31:0] best_age = '0;
      logic [31:0] age;
      for (int i = 0; i < SLOTS; i++) begin
         if (!m_valid[i]) continue;
         age = use_ctr - m_stamp[i];
         if (best < 0 || age > best_age) begin
            best = i;
            best_age = age;
         end
      end
      return best;
   endfunction

   function automatic void drop_slot(int i);
      if (m_valid[i]) begin
         m_valid[i] = 1'b0;
         byte_sum = byte_sum - m_bytes[i];
      end
   endfunction

   // Remove oldest entries while the byte total exceeds the budget.
   function automatic int trim_to_budget();
      logic [63:0] cap = 64'(budget_mb) << 20;
      int          n = 0;
      int          o;
      while (64'(byte_sum) > cap) begin
         o = oldest_slot();
         if (o < 0) break;
         drop_slot(o);
         n++;
      end
      return n;
   endfunction

   // Apply one request to the shadow index and return the response it causes.
   function automatic rsp_type predict_rsp(req_type r);
      rsp_type res = '0;
      int      k;
      int      ev = 0;
      int      o;
      bit      hit;
      case (r.operation)
         OP_STORE: begin
            if (cache_on) begin
               k = find_slot(r.frame_time, r.component_id);
               if (k < 0) begin
                  ev = trim_to_budget();
                  if (count_slots() >= SLOTS) begin
                     o = oldest_slot();
                     if (o >= 0) begin
                        drop_slot(o);
                        ev++;
                     end
                  end
                  for (int i = SLOTS - 1; i >= 0; i--) if (!m_valid[i]) k = i;
                  m_valid[k] = 1'b1;
                  m_time[k] = r.frame_time;
                  m_comp[k] = r.component_id;
                  m_bytes[k] = '0;
               end
               byte_sum = byte_sum - m_bytes[k] + r.byte_size;
               m_width[k] = r.frame_width;
               m_height[k] = r.frame_height;
               m_bytes[k] = r.byte_size;
               m_stamp[k] = use_ctr;
               use_ctr = use_ctr + 1;
               res.success = 1'b1;
            end
         end
         OP_LOAD: begin
            k = find_slot(r.frame_time, r.component_id);
            if (k >= 0) begin
               res.hit_width = m_width[k];
               res.hit_height = m_height[k];
               m_stamp[k] = use_ctr;
               use_ctr = use_ctr + 1;
               if (hit_ctr != '1) hit_ctr++;
               res.success = 1'b1;
            end else if (miss_ctr != '1) begin
               miss_ctr++;
            end
         end
         OP_PROBE: res.success = find_slot(r.frame_time, r.component_id) >= 0;
         OP_INVAL, OP_RANGE, OP_CLEAR: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!m_valid[i]) continue;
               if (r.operation == OP_INVAL)
                  hit = m_comp[i] == r.component_id && m_time[i] == r.frame_time;
               else if (r.operation == OP_RANGE)
                  hit = m_comp[i] == r.component_id && m_time[i] >= r.frame_time &&
                        m_time[i] <= r.range_end_time;
               else
                  hit = 1'b1;
               if (hit) begin
                  drop_slot(i);
                  ev++;
               end
            end
            res.success = ev > 0;
         end
         OP_EVICT: begin
            ev = trim_to_budget();
            res.success = ev > 0;
         end
         default: begin
            hit_ctr = '0;
            miss_ctr = '0;
         end
      endcase
      res.evicted_count = 6'(ev);
      res.entry_count = 6'(count_slots());
      res.total_bytes = byte_sum;
      res.hit_total = hit_ctr;
      res.miss_total = miss_ctr;
      return res;
   endfunction

   function automatic req_type make_req(logic [2:0] op, logic [31:0] t, logic [31:0] te,
                                        logic [15:0] c, logic [13:0] w, logic [13:0] h,
                                        logic [31:0] b);
      req_type r;
      r.operation = op;
      r.frame_time = t;
      r.range_end_time = te;
      r.component_id = c;
      r.frame_width = w;
      r.frame_height = h;
      r.byte_size = b;
      return r;
   endfunction

   function automatic void add_item(req_type r, bit typed = 1'b0, rsp_type want = '0);
      row_type row;
      row.kind = ROW_ITEM;
      row.item = r;
      row.typed = typed;
      row.want = want;
      row.csr_idx = '0;
      row.csr_val = '0;
      directed = {directed, row};
   endfunction

   function automatic void add_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      row_type row;
      row.kind = ROW_CSR;
      row.item = '0;
      row.typed = 1'b0;
      row.want = '0;
      row.csr_idx = idx;
      row.csr_val = val;
      directed = {directed, row};
   endfunction

   function automatic rsp_type make_rsp(bit s, logic [13:0] w, logic [13:0] h, int ev,
                                        int cnt, logic [39:0] tot, logic [31:0] hits,
                                        logic [31:0] misses);
      rsp_type x;
      x.success = s;
      x.hit_width = w;
      x.hit_height = h;
      x.evicted_count = 6'(ev);
      x.entry_count = 6'(cnt);
      x.total_bytes = tot;
      x.hit_total = hits;
      x.miss_total = misses;
      return x;
   endfunction

   // Random request: mostly keys from a small pool so hits and evictions occur.
   function automatic req_type random_req();
      req_type     r;
      int          pick = $urandom_range(99);
      int          sz = $urandom_range(99);
      logic [2:0]  op;
      if (pick < 35)      op = OP_STORE;
      else if (pick < 60) op = OP_LOAD;
      else if (pick < 70) op = OP_PROBE;
      else if (pick < 78) op = OP_INVAL;
      else if (pick < 85) op = OP_RANGE;
      else if (pick < 88) op = OP_CLEAR;
      else if (pick < 95) op = OP_EVICT;
      else                op = OP_STATS;
      r = make_req(op, $urandom, $urandom, 16'($urandom), 14'($urandom), 14'($urandom),
                   $urandom);
      if ($urandom_range(99) < 85) begin
         r.frame_time = $urandom_range(15);
         r.component_id = $urandom_range(3);
         r.range_end_time = r.frame_time + $urandom_range(8) - 2;
      end
      if (sz < 60)      r.byte_size = $urandom_range(1 << 20);
      else if (sz < 90) r.byte_size = $urandom_range(300) << 20;
      return r;
   endfunction

   // Compare one field and report a mismatch.
   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Response side: random stall, checking of every accepted item, watchdog.
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= $urandom_range(99) < recv_idle_pct;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("%0t: watchdog expired", $time);
            $display("byte_budget_lru_cache_index_tb failed");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: unexpected result item %h", $time, rsp_item);
               mismatch_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("success", want.success, rsp_item.success);
               check_field("hit_width", want.hit_width, rsp_item.hit_width);
               check_field("hit_height", want.hit_height, rsp_item.hit_height);
               check_field("evicted_count", want.evicted_count, rsp_item.evicted_count);
               check_field("entry_count", want.entry_count, rsp_item.entry_count);
               check_field("total_bytes", want.total_bytes, rsp_item.total_bytes);
               check_field("hit_total", want.hit_total, rsp_item.hit_total);
               check_field("miss_total", want.miss_total, rsp_item.miss_total);
            end
         end
      end
   end

   // Send one item, with random idle cycles first, and record its expected result.
   task automatic send_item(req_type r, bit typed, rsp_type want);
      rsp_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (req_stall);
      pred = predict_rsp(r);
      expected_rsp_q = {expected_rsp_q, (typed ? want : pred)};
   endtask

   // Wait until every expected result has come and the block has settled.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (QUIET_WAIT) @(posedge clock);
   endtask

   // Register write, issued only with the block idle.
   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_BUDGET) begin
         budget_mb = val;
         void'(trim_to_budget());
      end else if (idx == CSR_ENABLE) begin
         cache_on = val[0];
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [11:0] budget_pick [9];
      logic [11:0] b;
      budget_pick = '{12'd0, 12'd1, 12'd2, 12'd3, 12'd8, 12'd64,
                      12'd1024, 12'd4095, 12'd0};
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      mismatch_count = 0;
      send_idle_pct = 20;
      recv_idle_pct = 50;
      for (int i = 0; i < SLOTS; i++) begin
         m_valid[i] = 1'b0;
         m_time[i] = '0;
         m_comp[i] = '0;
         m_width[i] = '0;
         m_height[i] = '0;
         m_bytes[i] = '0;
         m_stamp[i] = '0;
      end
      use_ctr = '0;
      byte_sum = '0;
      hit_ctr = '0;
      miss_ctr = '0;
      budget_mb = BUDGET_RESET;
      cache_on = 1'b0;

      // Directed table: after reset the cache is disabled and empty.
      add_item(make_req(OP_STORE, 1, 0, 1, 5, 5, 100), 1, make_rsp(0, 0, 0, 0, 0, 0, 0, 0));
      add_item(make_req(OP_LOAD, 1, 0, 1, 0, 0, 0), 1, make_rsp(0, 0, 0, 0, 0, 0, 0, 1));
      add_item(make_req(OP_PROBE, 1, 0, 1, 0, 0, 0), 1, make_rsp(0, 0, 0, 0, 0, 0, 0, 1));
      add_item(make_req(OP_INVAL, 1, 0, 1, 0, 0, 0), 1, make_rsp(0, 0, 0, 0, 0, 0, 0, 1));
      add_item(make_req(OP_RANGE, 0, '1, 1, 0, 0, 0), 1, make_rsp(0, 0, 0, 0, 0, 0, 0, 1));
      add_item(make_req(OP_CLEAR, 0, 0, 0, 0, 0, 0), 1, make_rsp(0, 0, 0, 0, 0, 0, 0, 1));
      add_item(make_req(OP_EVICT, 0, 0, 0, 0, 0, 0), 1, make_rsp(0, 0, 0, 0, 0, 0, 0, 1));
      add_item(make_req(OP_STATS, 0, 0, 0, 0, 0, 0), 1, make_rsp(0, 0, 0, 0, 0, 0, 0, 0));
      add_csr(CSR_ENABLE, 12'd1);
      // All-ones key and sizes, then a second store that pushes it out over budget.
      add_item(make_req(OP_STORE, '1, 0, '1, '1, '1, '1), 1,
               make_rsp(1, 0, 0, 0, 1, 40'hFFFF_FFFF, 0, 0));
      add_item(make_req(OP_LOAD, '1, 0, '1, 0, 0, 0), 1,
               make_rsp(1, 14'h3FFF, 14'h3FFF, 0, 1, 40'hFFFF_FFFF, 1, 0));
      add_item(make_req(OP_STORE, 0, 0, 0, 0, 0, 0), 1, make_rsp(1, 0, 0, 1, 1, 0, 1, 0));
      add_item(make_req(OP_PROBE, 0, 0, 0, 0, 0, 0));
      // A reversed range matches nothing; overwrite of a key does not evict.
      add_item(make_req(OP_RANGE, 5, 0, 0, 0, 0, 0));
      add_item(make_req(OP_STORE, 0, 0, 0, 7, 9, 100));
      add_item(make_req(OP_RANGE, 0, '1, 0, 0, 0, 0));
      add_csr(CSR_BUDGET, 12'd0);
      add_item(make_req(OP_STORE, 1, 0, 1, 1, 1, 1));
      add_item(make_req(OP_STORE, 2, 0, 1, 2, 2, 0));
      add_item(make_req(OP_EVICT, 0, 0, 0, 0, 0, 0));
      add_item(make_req(OP_STORE, 3, 0, 1, 3, 3, 5));
      add_csr(CSR_BUDGET, 12'd4095);
      add_item(make_req(OP_EVICT, 0, 0, 0, 0, 0, 0));
      add_item(make_req(OP_LOAD, 9, 0, 9, 0, 0, 0));
      add_item(make_req(OP_INVAL, 2, 0, 1, 0, 0, 0));
      add_item(make_req(OP_CLEAR, 0, 0, 0, 0, 0, 0));
      add_item(make_req(OP_STATS, 0, 0, 0, 0, 0, 0));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CSR)
            write_csr(directed[i].csr_idx, directed[i].csr_val);
         else
            send_item(directed[i].item, directed[i].typed, directed[i].want);
      end

      // Random part in three idling phases; each phase starts from a drained block.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 50 : 0;
         recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 20 : 0;
         wait_drained();
         for (int i = 0; i < RAND_ITEMS / 3; i++) begin
            if (i % 61 == 0) begin
               b = budget_pick[$urandom_range(8)];
               if ($urandom_range(9) == 0) b = 12'($urandom);
               write_csr(CSR_BUDGET, b);
               write_csr(CSR_ENABLE, ($urandom_range(99) < 85) ? 12'd1 : 12'd0);
            end
            send_item(random_req(), 1'b0, '0);
         end
      end

      wait_drained();
      if (expected_rsp_q.size() != 0) mismatch_count++;
      if (mismatch_count == 0) begin
         $display("byte_budget_lru_cache_index_tb passed");
      end else begin
         $display("byte_budget_lru_cache_index_tb failed");
      end
      $finish;
   end

endmodule

[files.f]
rtl/bblci_pkg.sv
rtl/bblci_ram.sv
rtl/bblci_ctrl.sv
rtl/bblci_dpath.sv
rtl/byte_budget_lru_cache_index.sv
tb/byte_budget_lru_cache_index_tb.sv
